// ===== rtl/shs_pkg.sv =====
// ----------------------------------------------------------------------------
// shs_pkg: shared types, constants and round functions
// Word and state types, the SHA-256 round constants and initial hash value,
// and the per-round compression and message schedule step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package shs_pkg;

  // field widths
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned MSG_LO_W = 64;
  localparam int unsigned MSG_HI_W = 32;
  localparam int unsigned DIG_W    = 64;
  localparam int unsigned ROUNDS   = 64;

  localparam logic [LEN_W-1:0] MAX_MSG_BYTES = 5'd19;
  localparam logic [7:0]       PAD_MARKER    = 8'h80;

  typedef logic [31:0]     word_t;
  typedef word_t [7:0]     hstate_t;
  typedef word_t [15:0]    sched_t;

  // one pipeline stage: working variables and the 16-word schedule window
  typedef struct packed {
    hstate_t st;
    sched_t  w;
  } rnd_t;

  localparam word_t ROUND_K [ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // initial hash value, a in index 0
  localparam hstate_t H_INIT = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t ssig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t bsig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // one compression round plus one schedule step
  function automatic rnd_t sha_round(rnd_t x, word_t k);
    rnd_t  r;
    word_t t1;
    word_t t2;
    word_t chv;
    word_t majv;
    chv  = (x.st[4] & x.st[5]) ^ (~x.st[4] & x.st[6]);
    majv = (x.st[0] & x.st[1]) ^ (x.st[0] & x.st[2]) ^ (x.st[1] & x.st[2]);
    t1   = x.st[7] + bsig1(x.st[4]) + chv + k + x.w[0];
    t2   = bsig0(x.st[0]) + majv;
    r.st[0] = t1 + t2;
    r.st[1] = x.st[0];
    r.st[2] = x.st[1];
    r.st[3] = x.st[2];
    r.st[4] = x.st[3] + t1;
    r.st[5] = x.st[4];
    r.st[6] = x.st[5];
    r.st[7] = x.st[6];
    for (int i = 0; i < 15; i++) begin
      r.w[i] = x.w[i+1];
    end
    r.w[15] = x.w[0] + ssig0(x.w[1]) + x.w[9] + ssig1(x.w[14]);
    return r;
  endfunction

endpackage

// ===== rtl/shs_if.sv =====
// ----------------------------------------------------------------------------
// shs_if: message and digest channels
// Valid/ready channels carrying one message item in and one digest item out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface shs_in_if;
  import shs_pkg::*;

  logic                valid;
  logic                ready;
  logic [MSG_LO_W-1:0] msg_bytes_low;
  logic [MSG_LO_W-1:0] msg_bytes_mid;
  logic [MSG_HI_W-1:0] msg_bytes_high;

  modport source (
    output valid, msg_bytes_low, msg_bytes_mid, msg_bytes_high,
    input  ready
  );
  modport sink (
    input  valid, msg_bytes_low, msg_bytes_mid, msg_bytes_high,
    output ready
  );
endinterface

interface shs_out_if;
  import shs_pkg::*;

  logic             valid;
  logic             ready;
  logic [DIG_W-1:0] digest_part0;
  logic [DIG_W-1:0] digest_part1;
  logic [DIG_W-1:0] digest_part2;
  logic [DIG_W-1:0] digest_part3;

  modport source (
    output valid, digest_part0, digest_part1, digest_part2, digest_part3,
    input  ready
  );
  modport sink (
    input  valid, digest_part0, digest_part1, digest_part2, digest_part3,
    output ready
  );
endinterface

// ===== rtl/sha256_short_message_hash.sv =====
// ----------------------------------------------------------------------------
// sha256_short_message_hash: pipelined SHA-256 of a 0 to 19 byte message
// The digest item passes the padding stage, 64 round stages and the final
//   add into the output register; one round per stage, all stages in flight.
// Throughput: one item per cycle while the skid entry is free.
// A two-entry output buffer keeps input ready high while one digest waits.
// Reset clears all valid bits and sets the message length to zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_short_message_hash (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [shs_pkg::LEN_W-1:0] cfg_wdata_i,
  shs_in_if.sink                   msg_i,
  shs_out_if.source                dig_o
);
  import shs_pkg::*;

  localparam int unsigned MSG_BITS = 2 * MSG_LO_W + MSG_HI_W;
  localparam int unsigned MSG_BYTES = MSG_BITS / 8;

  logic [LEN_W-1:0] msg_len_q;

  logic             adv;
  rnd_t             pad_d;
  rnd_t             stg_q [ROUNDS+1];
  logic [ROUNDS:0]  vld_q;

  hstate_t          fin_d;
  logic             fin_vld;

  hstate_t          out_dat_q;
  logic             out_vld_q;
  hstate_t          skid_dat_q;
  logic             skid_vld_q;

  // length register, out-of-range writes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msg_len_q <= '0;
    end else if (cfg_we_i && (cfg_wdata_i <= MAX_MSG_BYTES)) begin
      msg_len_q <= cfg_wdata_i;
    end
  end

  // pipeline moves while the skid entry is free
  assign adv         = !skid_vld_q;
  assign msg_i.ready = adv;

  // build the padded block: masked bytes, marker, bit length
  always_comb begin
    logic [MSG_BITS-1:0]  msg;
    logic [7:0]           blk [MSG_BYTES];
    msg = {msg_i.msg_bytes_low, msg_i.msg_bytes_mid, msg_i.msg_bytes_high};
    for (int i = 0; i < MSG_BYTES; i++) begin
      if (LEN_W'(i) < msg_len_q) begin
        blk[i] = msg[MSG_BITS-1-8*i -: 8];
      end else if (LEN_W'(i) == msg_len_q) begin
        blk[i] = PAD_MARKER;
      end else begin
        blk[i] = '0;
      end
    end
    pad_d.st = H_INIT;
    pad_d.w  = '0;
    for (int j = 0; j < MSG_BYTES / 4; j++) begin
      pad_d.w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    end
    pad_d.w[15] = {24'd0, msg_len_q, 3'b000};
  end

  // padding stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= msg_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= pad_d;
    end
  end

  // round stages, one round each
  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[r+1] <= 1'b0;
      end else if (adv) begin
        vld_q[r+1] <= vld_q[r];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        stg_q[r+1] <= sha_round(stg_q[r], ROUND_K[r]);
      end
    end
  end

  // final feed-forward add
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fin_d[i] = stg_q[ROUNDS].st[i] + H_INIT[i];
    end
  end

  assign fin_vld = vld_q[ROUNDS] && adv;

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || dig_o.ready) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end else begin
        out_vld_q  <= fin_vld;
      end
    end else if (fin_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || dig_o.ready) begin
      out_dat_q <= skid_vld_q ? skid_dat_q : fin_d;
    end else if (fin_vld) begin
      skid_dat_q <= fin_d;
    end
  end

  assign dig_o.valid        = out_vld_q;
  assign dig_o.digest_part0 = {out_dat_q[0], out_dat_q[1]};
  assign dig_o.digest_part1 = {out_dat_q[2], out_dat_q[3]};
  assign dig_o.digest_part2 = {out_dat_q[4], out_dat_q[5]};
  assign dig_o.digest_part3 = {out_dat_q[6], out_dat_q[7]};

`ifndef ASSERT_OFF
  // skid entry only fills behind a waiting digest
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid without output item");

  // a finished item meeting a stalled output lands in the skid entry
  a_skid_catch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !dig_o.ready && vld_q[ROUNDS] && !skid_vld_q) |=> skid_vld_q)
    else $error("finished item dropped at stalled output");

  // an accepted item enters the padding stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (msg_i.valid && msg_i.ready) |=> vld_q[0])
    else $error("accepted item lost at pipeline entry");

  // length register never leaves its range
  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    msg_len_q <= MAX_MSG_BYTES)
    else $error("message length out of range");
`endif

endmodule

// ===== bench/shs_digest_check.sv =====
// ----------------------------------------------------------------------------
// shs_digest_check: digest predictor and comparator
// Watches the length register writes and both channels, works out the SHA-256
// digest of every message item taken in and compares each digest item given
// out, in order and part by part, against the oldest digest still awaited.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shs_digest_check (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [shs_pkg::LEN_W-1:0] cfg_wdata_i,
  shs_in_if                         msg_i,
  shs_out_if                        dig_i,
  output int unsigned               fail_count_o,
  output int unsigned               pending_o
);
  import shs_pkg::*;

  localparam int unsigned LONGEST_MSG = 19;

  // digest as four 64-bit parts, part 0 first
  typedef logic [0:3][63:0] digest_t;

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [LEN_W-1:0] msg_len;
  digest_t          awaited_digests [$];
  int unsigned      fails;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // pad the message into one block and run a single compression
  function automatic digest_t sha256_of_message(logic [LEN_W-1:0] len, logic [63:0] lo,
                                                logic [63:0] mid, logic [31:0] hi);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0;
    logic [31:0] s1;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [15:0] bit_len;
    digest_t     d;
    for (int i = 0; i < 64; i++) begin
      blk[i] = 8'h00;
    end
    for (int i = 0; i < 8; i++) begin
      blk[i]     = lo[63 - 8 * i -: 8];
      blk[8 + i] = mid[63 - 8 * i -: 8];
    end
    for (int i = 0; i < 4; i++) begin
      blk[16 + i] = hi[31 - 8 * i -: 8];
    end
    // bytes past the length carry nothing
    for (int i = int'(len); i < 20; i++) begin
      blk[i] = 8'h00;
    end
    blk[len] = 8'h80;
    bit_len  = 16'(len) << 3;
    blk[62]  = bit_len[15:8];
    blk[63]  = bit_len[7:0];

    // message schedule
    for (int i = 0; i < 16; i++) begin
      w[i] = {blk[4 * i], blk[4 * i + 1], blk[4 * i + 2], blk[4 * i + 3]};
    end
    for (int i = 16; i < 64; i++) begin
      s0   = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
      s1   = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
      w[i] = w[i - 16] + s0 + w[i - 7] + s1;
    end

    // 64 rounds from the initial value
    for (int j = 0; j < 8; j++) begin
      v[j] = IV_TAB[j];
    end
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 4; j++) begin
      d[j] = {v[2 * j] + IV_TAB[2 * j], v[2 * j + 1] + IV_TAB[2 * j + 1]};
    end
    return d;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    digest_t want;
    digest_t got;
    if (!rst_ni) begin
      msg_len = '0;
      fails   = 0;
      awaited_digests.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // message item taken: predict with the length in force before this edge
      if (msg_i.valid && msg_i.ready) begin
        awaited_digests.push_back(sha256_of_message(msg_len, msg_i.msg_bytes_low,
                                                    msg_i.msg_bytes_mid,
                                                    msg_i.msg_bytes_high));
      end
      // digest item given out
      if (dig_i.valid && dig_i.ready) begin
        got = {dig_i.digest_part0, dig_i.digest_part1, dig_i.digest_part2,
               dig_i.digest_part3};
        if (awaited_digests.size() == 0) begin
          $display("%0t: digest item with none awaited: expected none actual %h", $time, got);
          fails++;
        end else begin
          want = awaited_digests.pop_front();
          for (int j = 0; j < 4; j++) begin
            if (got[j] !== want[j]) begin
              $display("%0t: digest_part%0d expected %h actual %h", $time, j, want[j], got[j]);
              fails++;
            end
          end
        end
      end
      // lengths beyond the longest message are dropped
      if (cfg_we_i && cfg_wdata_i <= LONGEST_MSG) begin
        msg_len = cfg_wdata_i;
      end
      fail_count_o <= fails;
      pending_o    <= awaited_digests.size();
    end
  end

endmodule

// ===== bench/tb_sha256_short_message_hash.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_short_message_hash: testbench top for the short message hasher
// Resets the block, sets the message length through several values, the
// extremes and dropped writes among them, then sends directed and random
// message items with random gaps and digest stalls, one long digest hold-off
// that backs the pipeline up, and gives the verdict from the digest checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sha256_short_message_hash;
  import shs_pkg::*;

  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned PHASES         = 12;
  localparam int unsigned ITEMS_PER_PH   = 125;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned DRAIN_CYCLES   = 80;
  localparam int unsigned STALL_LIMIT    = 4000;
  localparam int unsigned PRESSURE_PHASE = 4;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;
  int unsigned      fail_count;
  int unsigned      pending;
  bit               gaps_on;
  bit               hold_req;
  int unsigned      quiet_cycles;

  shs_in_if  msg_if ();
  shs_out_if dig_if ();

  always #2 clk = ~clk;

  sha256_short_message_hash i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .msg_i       (msg_if.sink),
    .dig_o       (dig_if.source)
  );

  shs_digest_check i_digest_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .msg_i        (msg_if),
    .dig_i        (dig_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // offer one message item, after a random gap, and wait until it is taken
  task automatic send_msg(logic [63:0] lo, logic [63:0] mid, logic [31:0] hi);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      msg_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_if.valid          <= 1'b1;
    msg_if.msg_bytes_low  <= lo;
    msg_if.msg_bytes_mid  <= mid;
    msg_if.msg_bytes_high <= hi;
    do @(posedge clk); while (!msg_if.ready);
  endtask

  // random message content, sometimes all zero or all one
  task automatic send_random_msg();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      send_msg('0, '0, '0);
    end else if (pick == 1) begin
      send_msg('1, '1, '1);
    end else begin
      send_msg({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());
    end
  endtask

  // stop offering and wait for every awaited digest
  task automatic wait_idle();
    msg_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_length(logic [LEN_W-1:0] len);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // digest side: random stalls, and one long hold-off on request
  initial begin
    int unsigned stall;
    bit          hold_done;
    hold_done = 1'b0;
    dig_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = gaps_on ? $urandom_range(0, 13) : 0;
      if (hold_req && !hold_done) begin
        stall     = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (stall > 0) begin
        dig_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dig_if.ready <= 1'b1;
      do @(posedge clk); while (!dig_if.valid);
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (msg_if.valid && msg_if.ready) || (dig_if.valid && dig_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stimulus and verdict
  initial begin
    logic [LEN_W-1:0] len;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    msg_if.valid          <= 1'b0;
    msg_if.msg_bytes_low  <= '0;
    msg_if.msg_bytes_mid  <= '0;
    msg_if.msg_bytes_high <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty message from reset, stray bytes must not matter
    send_msg('1, '1, '1);
    send_msg('0, '0, '0);

    // longest message, extreme and alternating bytes
    write_length(5'd19);
    send_msg('1, '1, '1);
    send_msg('0, '0, '0);
    send_msg({16{4'ha}}, {16{4'h5}}, {8{4'ha}});
    send_msg({16{4'h5}}, {16{4'ha}}, {8{4'h5}});

    // lengths over nineteen are dropped, nineteen stays
    write_length(5'd20);
    send_msg({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());
    write_length(5'd31);
    send_msg('1, '1, '1);

    // marker at word and field boundaries
    write_length(5'd1);
    send_msg('1, '1, '1);
    send_msg(64'h8000_0000_0000_0000, '0, '0);
    write_length(5'd3);
    send_msg({$urandom(), $urandom()}, '1, '1);
    write_length(5'd4);
    send_msg({$urandom(), $urandom()}, '1, '1);
    write_length(5'd7);
    send_msg('1, '1, '1);
    write_length(5'd8);
    send_msg('1, '1, '1);
    write_length(5'd15);
    send_msg('1, '1, '1);
    write_length(5'd16);
    send_msg('1, '1, '1);
    write_length(5'd18);
    send_msg('1, '1, '1);
    write_length(5'd0);
    send_msg({$urandom(), $urandom()}, {$urandom(), $urandom()}, $urandom());

    // random phases, one per length setting
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        len = 5'd0;
      end else if (p == 1) begin
        len = 5'd19;
      end else begin
        len = LEN_W'($urandom_range(0, 19));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_length(LEN_W'($urandom_range(20, 31)));
      end
      write_length(len);
      gaps_on = (p % 3 != 0);
      if (p == PRESSURE_PHASE) begin
        gaps_on  = 1'b0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < ITEMS_PER_PH; n++) begin
        send_random_msg();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
